// ===== rtl/core/iss_pkg.sv =====
// ----------------------------------------------------------------------------
// iss_pkg
// Shared constants and types for the insertion sorter cell chain.
// ----------------------------------------------------------------------------
package iss_pkg;

    localparam int MAX_LEN = 16;
    localparam int DATA_W  = 32;
    localparam int CNT_W   = $clog2(MAX_LEN + 1);

    typedef enum logic [1:0] {
        ST_IDLE  = 2'b01,
        ST_DRAIN = 2'b10
    } t_state;

    typedef enum logic [1:0] {
        OP_HOLD   = 2'd0,
        OP_INSERT = 2'd1,
        OP_SHIFT  = 2'd2
    } t_cell_op;

    typedef struct packed {
        t_cell_op                  op;
        logic signed [DATA_W-1:0]  value;
    } t_cell_ctrl;

endpackage

// ===== rtl/core/iss_cell.sv =====
// ----------------------------------------------------------------------------
// iss_cell
// One slot of the sorted chain: compares against the broadcast item,
// takes the new value or its left neighbor on insert, its right on drain.
// ----------------------------------------------------------------------------
module iss_cell
    import iss_pkg::*;
(
    input  logic                     i_clk,
    input  t_cell_ctrl               i_ctrl,
    input  logic                     i_occupied,
    input  logic                     i_left_gt,
    input  logic signed [DATA_W-1:0] i_left_value,
    input  logic signed [DATA_W-1:0] i_right_value,
    output logic signed [DATA_W-1:0] o_value,
    output logic                     o_gt
);

    logic signed [DATA_W-1:0] r_value;
    logic signed [DATA_W-1:0] n_value;

    // empty slots count as greater so the item lands at the end
    assign o_gt    = !i_occupied || (r_value > i_ctrl.value);
    assign o_value = r_value;

    always_comb begin
        n_value = r_value;
        case (i_ctrl.op)
            OP_INSERT: begin
                if (o_gt) begin
                    n_value = i_left_gt ? i_left_value : i_ctrl.value;
                end
            end
            OP_SHIFT: begin
                n_value = i_right_value;
            end
            default: begin
                n_value = r_value;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

endmodule

// ===== rtl/core/insertion_sorter_unit.sv =====
// ----------------------------------------------------------------------------
// insertion_sorter_unit
// Stable ascending insertion sorter built from a chain of compare/shift cells.
// ----------------------------------------------------------------------------
// Input stream: one signed 32-bit value per item, tlast closes the set.
// Each accepted item is compared in every cell at once and slotted into the
// chain, so one item per cycle is taken while the set is collected. Equal
// values stay in arrival order.
// After the item with tlast is accepted, the chain drains from cell 0 toward
// the output, one sorted item per cycle while the receiver is ready; the
// first result is shown the cycle after tlast was accepted. tlast marks the
// final result, tuser is set on every result of a set that lost items to a
// full chain (items beyond MAX_LEN are dropped). The input is held off while
// the chain drains.
// If the receiver stalls, the current result holds and the chain does not
// shift. Reset empties the chain and clears the overflow flag.
// ----------------------------------------------------------------------------
module insertion_sorter_unit
    import iss_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // [31:0] value
    input  logic        i_s_axis_tlast,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // [31:0] sorted_value
    output logic        o_m_axis_tlast,
    output logic        o_m_axis_tuser    // [0] overflowed
);

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_ovf, n_ovf;
    t_cell_ctrl       w_ctrl;

    logic signed [DATA_W-1:0] w_value [MAX_LEN];
    logic                     w_gt    [MAX_LEN];

    logic w_in_acc;
    logic w_out_acc;

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_m_axis_tvalid = (r_state == ST_DRAIN);
    assign w_in_acc        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_acc       = o_m_axis_tvalid && i_m_axis_tready;

    assign o_m_axis_tdata  = w_value[0];
    assign o_m_axis_tlast  = (r_count == CNT_W'(1));
    assign o_m_axis_tuser  = r_ovf;

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_ovf        = r_ovf;
        w_ctrl.op    = OP_HOLD;
        w_ctrl.value = i_s_axis_tdata;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    if (r_count < CNT_W'(MAX_LEN)) begin
                        w_ctrl.op = OP_INSERT;
                        n_count   = r_count + CNT_W'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_s_axis_tlast) begin
                        n_state = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN: begin
                if (w_out_acc) begin
                    w_ctrl.op = OP_SHIFT;
                    n_count   = r_count - CNT_W'(1);
                    if (o_m_axis_tlast) begin
                        n_state = ST_IDLE;
                        n_ovf   = 1'b0;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_ovf   <= n_ovf;
        end
    end

    for (genvar i = 0; i < MAX_LEN; i++) begin : g_cell
        logic                     w_left_gt;
        logic signed [DATA_W-1:0] w_left_value;
        logic signed [DATA_W-1:0] w_right_value;

        if (i == 0) begin : g_head
            assign w_left_gt    = 1'b0;
            assign w_left_value = '0;
        end else begin : g_body
            assign w_left_gt    = w_gt[i-1];
            assign w_left_value = w_value[i-1];
        end

        if (i == MAX_LEN - 1) begin : g_tail
            assign w_right_value = '0;
        end else begin : g_inner
            assign w_right_value = w_value[i+1];
        end

        iss_cell u_cell (
            .i_clk         (i_clk),
            .i_ctrl        (w_ctrl),
            .i_occupied    (CNT_W'(i) < r_count),
            .i_left_gt     (w_left_gt),
            .i_left_value  (w_left_value),
            .i_right_value (w_right_value),
            .o_value       (w_value[i]),
            .o_gt          (w_gt[i])
        );
    end

endmodule

// ===== rtl/core/iss_checker.sv =====
// ----------------------------------------------------------------------------
// iss_checker
// Port-level checks for the insertion sorter, bound to the top level.
// ----------------------------------------------------------------------------
module iss_checker
    import iss_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tvalid,
    input logic        o_s_axis_tready,
    input logic [31:0] i_s_axis_tdata,
    input logic        i_s_axis_tlast,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [31:0] o_m_axis_tdata,
    input logic        o_m_axis_tlast,
    input logic        o_m_axis_tuser
);

    logic w_in_last;
    logic w_out_acc;

    assign w_in_last = i_s_axis_tvalid && o_s_axis_tready && i_s_axis_tlast;
    assign w_out_acc = o_m_axis_tvalid && i_m_axis_tready;

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_s_axis_tready && o_m_axis_tvalid))
        else $error("input ready while draining");

    a_drain_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_last |=> o_m_axis_tvalid)
        else $error("no result after closing item");

    a_drain_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_acc && o_m_axis_tlast) |=> !o_m_axis_tvalid && o_s_axis_tready)
        else $error("drain did not finish after final item");

    a_ascending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_acc && !o_m_axis_tlast) |=> o_m_axis_tvalid &&
            ($signed(o_m_axis_tdata) >= $signed($past(o_m_axis_tdata))) &&
            (o_m_axis_tuser == $past(o_m_axis_tuser)))
        else $error("results out of order");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=> o_m_axis_tvalid &&
            $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast))
        else $error("stalled result changed");

endmodule

bind insertion_sorter_unit iss_checker u_iss_checker (.*);
